// File: hdl/base_n_text_to_integer_defines.svh
// Assertion macros shared by the base-N text to integer RTL.
// Depends on nothing; the assertion bodies compile out when SYNTHESIS is set.
`ifndef BASE_N_TEXT_TO_INTEGER_DEFINES_SVH
`define BASE_N_TEXT_TO_INTEGER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset
`define BTTI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btti assertion failed");
// Condition must never be true outside reset
`define BTTI_ASSERT_NEVER(label, clk, rst_n, cond) \
    `BTTI_ASSERT(label, clk, rst_n, !(cond))
`else
`define BTTI_ASSERT(label, clk, rst_n, prop)
`define BTTI_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hdl/btti_pkg.sv
// Types and constants for the base-N text to integer converter.
// No dependencies; imported by every module and interface of the block.
package btti_pkg;

    // Field widths
    localparam int SYMBOL_W = 8;
    localparam int RADIX_W  = 6;
    localparam int MAG_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [RADIX_W-1:0]  radix_t;
    typedef logic [SYMBOL_W-1:0] symbol_t;
    typedef logic [MAG_W-1:0]    mag_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Radix limits and reset value
    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t RADIX_RESET = 6'd10;

    // Largest magnitude (INT_MAX)
    localparam mag_t INT_MAX = 31'h7FFF_FFFF;

    // Result status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_SYMBOL = 2'd1;
    localparam status_t STATUS_OVERFLOW  = 2'd2;

    // ASCII codes
    localparam symbol_t CH_PLUS  = 8'h2B;
    localparam symbol_t CH_MINUS = 8'h2D;
    localparam symbol_t CH_0     = 8'h30;
    localparam symbol_t CH_9     = 8'h39;
    localparam symbol_t CH_UA    = 8'h41;
    localparam symbol_t CH_UZ    = 8'h5A;
    localparam symbol_t CH_LA    = 8'h61;
    localparam symbol_t CH_LZ    = 8'h7A;
    localparam symbol_t CASE_OFS = 8'h20;
    // 'A' maps to digit value 10
    localparam symbol_t LETTER_BASE = 8'd10;

    // Class of one character as decided by the front end
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DIGIT,
        KIND_PLUS,
        KIND_MINUS,
        KIND_BAD
    } kind_t;

    // Entry carried from front end to back end
    typedef struct packed {
        kind_t  kind;
        radix_t digit;
        logic   last;
    } entry_t;

endpackage

// File: hdl/btti_in_if.sv
// Character channel: valid/ready handshake carrying one ASCII character word.
// Depends on btti_pkg.
interface btti_in_if
    import btti_pkg::*;
;
    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    has_symbol;
    logic    last;

    modport source (output valid, output symbol, output has_symbol, output last,
                    input ready);
    modport sink   (input valid, input symbol, input has_symbol, input last,
                    output ready);
endinterface

// File: hdl/btti_out_if.sv
// Result channel: valid/ready handshake carrying the converted value and status.
// Depends on btti_pkg.
interface btti_out_if
    import btti_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    status_t                   status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// File: hdl/base_n_text_to_integer.sv
// Top level of the base-N text to integer converter: radix register and block wiring.
// Depends on btti_pkg, btti_in_if, btti_out_if, btti_front, btti_queue and btti_back.

// Converts an ASCII number string, one character word per cycle, into a signed 32-bit
// value in a radix of 2 to 36 held in the radix register (reset 10). Lower-case letters
// count as upper case, a leading '+' or '-' is allowed, and the word marked last returns
// the value with status 0 ok, 1 bad symbol or 2 overflow past 2147483647 (value 0 on
// error). A word with has_symbol low carries no character; with last set it closes the
// string. Sustained rate is one word per cycle while no result waits; the back end
// retires one word each cycle with a single 31x6 multiply, add and compare against the
// limit. A last word is registered in the queue, then in the result register; the queue
// of QUEUE_DEPTH words takes words while a result waits. No clearing pass after reset.
// Write the radix only while no string is in progress.
module base_n_text_to_integer
    import btti_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  radix_t      cfg_wdata,
    btti_in_if.sink     chars,
    btti_out_if.source  results
);

    radix_t radix_reg;
    logic   push_valid, push_ready;
    entry_t push_data;
    logic   pop_valid, pop_ready;
    entry_t pop_data;

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_we)
            radix_reg <= cfg_wdata;
    end

    btti_front u_front (
        .chars      (chars),
        .radix      (radix_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    btti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    btti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule

// File: hdl/btti_front.sv
// Front end: accepts character words, folds case and classifies each one.
// Depends on btti_pkg and btti_in_if; feeds btti_queue.
module btti_front
    import btti_pkg::*;
(
    btti_in_if.sink chars,
    input  radix_t  radix,
    output logic    push_valid,
    input  logic    push_ready,
    output entry_t  push_data
);

    symbol_t folded;
    symbol_t dval;
    logic    radix_bad;

    // Handshake passes straight to the queue
    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

    assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);

    // Fold lower case to upper case
    always_comb
    begin
        if (chars.symbol >= CH_LA && chars.symbol <= CH_LZ)
            folded = chars.symbol - CASE_OFS;
        else
            folded = chars.symbol;
    end

    // Classify; an out-of-range radix makes every word a bad symbol
    always_comb
    begin
        dval            = '0;
        push_data.kind  = KIND_BAD;
        push_data.last  = chars.last;
        if (folded >= CH_0 && folded <= CH_9)
            dval = folded - CH_0;
        else if (folded >= CH_UA && folded <= CH_UZ)
            dval = folded - CH_UA + LETTER_BASE;
        push_data.digit = dval[RADIX_W-1:0];

        priority if (radix_bad)
            push_data.kind = KIND_BAD;
        else if (!chars.has_symbol)
            push_data.kind = KIND_NONE;
        else if (folded == CH_PLUS)
            push_data.kind = KIND_PLUS;
        else if (folded == CH_MINUS)
            push_data.kind = KIND_MINUS;
        else if (((folded >= CH_0 && folded <= CH_9) || (folded >= CH_UA && folded <= CH_UZ))
                 && dval < {2'b00, radix})
            push_data.kind = KIND_DIGIT;
        else
            push_data.kind = KIND_BAD;
    end

endmodule

// File: hdl/btti_queue.sv
// Short FIFO of classified entries between front end and back end.
// Depends on btti_pkg and the assertion macros header.
`include "base_n_text_to_integer_defines.svh"
module btti_queue
    import btti_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    `BTTI_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `BTTI_ASSERT(a_empty_ptrs, clk, rst_n, count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
    `BTTI_ASSERT(a_push_grows, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// File: hdl/btti_back.sv
// Back end: folds classified entries into the magnitude and drives the result register.
// Depends on btti_pkg, btti_out_if and the assertion macros header.
`include "base_n_text_to_integer_defines.svh"
module btti_back
    import btti_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  radix_t  radix,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  entry_t  pop_data,
    btti_out_if.source results
);

    localparam int PROD_W = MAG_W + RADIX_W;
    localparam int SUM_W  = PROD_W + 1;

    mag_t    acc_reg, acc_next;
    logic    neg_reg, neg_next;
    logic    first_reg, first_next;
    status_t err_reg, err_next;

    logic    res_valid_reg;
    mag_t    res_mag_reg;
    logic    res_neg_reg;
    status_t res_status_reg;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [VALUE_W-1:0] mag_ext;
    logic              pop;

    // Only a last entry needs room in the result register
    assign pop_ready = !pop_data.last || !res_valid_reg || results.ready;
    assign pop       = pop_valid && pop_ready;

    // Multiply-accumulate for one digit
    assign prod = PROD_W'(acc_reg) * PROD_W'(radix);
    assign sum  = SUM_W'(prod) + SUM_W'(pop_data.digit);

    // Next string state from one entry; errors are sticky
    always_comb
    begin
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        err_next   = err_reg;
        if (err_reg == STATUS_OK)
        begin
            unique case (pop_data.kind)
                KIND_NONE:
                begin
                end
                KIND_DIGIT:
                begin
                    first_next = 1'b0;
                    if (sum > SUM_W'(INT_MAX))
                        err_next = STATUS_OVERFLOW;
                    else
                        acc_next = sum[MAG_W-1:0];
                end
                KIND_PLUS, KIND_MINUS:
                begin
                    if (!first_reg)
                        err_next = STATUS_BAD_SYMBOL;
                    else
                    begin
                        first_next = 1'b0;
                        if (pop_data.kind == KIND_MINUS)
                            neg_next = 1'b1;
                    end
                end
                KIND_BAD:
                begin
                    first_next = 1'b0;
                    err_next   = STATUS_BAD_SYMBOL;
                end
                default:
                begin
                    err_next = STATUS_BAD_SYMBOL;
                end
            endcase
        end
    end

    // String state; cleared after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            first_reg <= 1'b1;
            err_reg   <= STATUS_OK;
        end
        else if (pop)
        begin
            if (pop_data.last)
            begin
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                first_reg <= 1'b1;
                err_reg   <= STATUS_OK;
            end
            else
            begin
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                first_reg <= first_next;
                err_reg   <= err_next;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (pop && pop_data.last)
            res_valid_reg <= 1'b1;
        else if (results.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload; value is zero on error
    always_ff @(posedge clk)
    begin
        if (pop && pop_data.last)
        begin
            res_mag_reg    <= (err_next == STATUS_OK) ? acc_next : '0;
            res_neg_reg    <= neg_next && (err_next == STATUS_OK);
            res_status_reg <= err_next;
        end
    end

    assign mag_ext        = {1'b0, res_mag_reg};
    assign results.valid  = res_valid_reg;
    assign results.status = res_status_reg;
    assign results.value  = $signed(res_neg_reg ? (VALUE_W'(0) - mag_ext) : mag_ext);

    `BTTI_ASSERT(a_clear_after_last, clk, rst_n, pop && pop_data.last |=> first_reg && err_reg == STATUS_OK && acc_reg == '0)
    `BTTI_ASSERT(a_err_sticky, clk, rst_n, err_reg != STATUS_OK && !(pop && pop_data.last) |=> err_reg == $past(err_reg))
    `BTTI_ASSERT(a_acc_idle, clk, rst_n, !pop |=> $stable(acc_reg))

endmodule
